// ===== hdl/modular_exponentiation_unit_assert.svh =====
// Assertion macros for the modular exponentiation unit.
// Included by the checker; depends on nothing else.
`ifndef MODULAR_EXPONENTIATION_UNIT_ASSERT_SVH
`define MODULAR_EXPONENTIATION_UNIT_ASSERT_SVH

// Plain property, sampled on the rising clock, held off during reset.
`define MEU_ASSERT(name, clk, rst_n, prop, msg) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Consequent checked in the same cycle as the antecedent.
`define MEU_ASSERT_SAME(name, clk, rst_n, ante, cons, msg) \
	`MEU_ASSERT(name, clk, rst_n, (ante) |-> (cons), msg)

// Consequent checked in the cycle after the antecedent.
`define MEU_ASSERT_NEXT(name, clk, rst_n, ante, cons, msg) \
	`MEU_ASSERT(name, clk, rst_n, (ante) |=> (cons), msg)

`endif

// ===== hdl/modexp_pkg.sv =====
// Shared constants of the modular exponentiation unit.
// No dependencies; imported by the sequencer and the top level.
`timescale 1ns / 1ps

package modexp_pkg;

	// Command codes
	localparam logic CMD_POWER   = 1'b0;
	localparam logic CMD_INVERSE = 1'b1;

	// Register index of the modulus register
	localparam logic REG_MODULUS = 1'b0;

	// Modulus after reset, cut to the modulus width where it is used
	localparam logic [63:0] MODULUS_RESET = 64'd1000000007;

endpackage

// ===== hdl/modular_exponentiation_unit.sv =====
// Modular exponentiation unit, top level: modulus register, sequencer, multiplier.
// Depends on modexp_pkg, modexp_mulser and modexp_seq.
`timescale 1ns / 1ps

// Use:
//   Configuration: the modulus register sits at byte address 0 of the APB-style
//   port; pready is always high, a write lands at the access cycle. Write it only
//   while busy is low and no result is pending.
//   Command: drive cmd, base, exponent with start; the word is taken at the clock
//   edge where start is high and busy is low. cmd selects power (base^exponent)
//   or inverse (base^(modulus-2), an inverse only for a prime modulus).
//   Result: result is valid for exactly one cycle while done is high; the
//   receiver cannot stall it, so capture it then. busy is low in that cycle and a
//   new command may be taken at the same edge.
//   Products: each modular product runs on one bit-serial multiplier, one bit of
//   the multiplier operand per cycle. A command takes one product to reduce the
//   base, one square per exponent bit and one multiply per set bit of the
//   exponent used. With a modulus below two the result (zero) follows in the
//   cycle after accept.
//   Reset: the modulus returns to 1000000007 (cut to MOD_BITS), the block is idle.
module modular_exponentiation_unit #(
	parameter int EXP_BITS = 32,
	parameter int MOD_BITS = 30,
	localparam int DATA_W  = (MOD_BITS > 32) ? 64 : 32,
	localparam int BYTE_W  = (MOD_BITS > 32) ? 3 : 2,
	localparam int ADDR_W  = BYTE_W + 1
) (
	input  logic                clk,
	input  logic                arst_n,
	// configuration port
	input  logic                psel,
	input  logic                penable,
	input  logic                pwrite,
	input  logic [ADDR_W-1:0]   paddr,
	input  logic [DATA_W-1:0]   pwdata,
	output logic [DATA_W-1:0]   prdata,
	output logic                pready,
	// command channel
	input  logic                start,
	output logic                busy,
	input  logic                cmd,
	input  logic [MOD_BITS-1:0] base,
	input  logic [EXP_BITS-1:0] exponent,
	// result channel
	output logic                done,
	output logic [MOD_BITS-1:0] result
);

	import modexp_pkg::*;

	logic [MOD_BITS-1:0] modulus_q;
	logic                cfg_write;
	logic                reg_hit;

	logic                mul_start;
	logic [MOD_BITS-1:0] mul_a;
	logic [MOD_BITS-1:0] mul_b;
	logic                mul_done;
	logic [MOD_BITS-1:0] mul_prod;

	// decode: the top address bit is the register index, the rest are byte lanes
	assign reg_hit   = (paddr[ADDR_W-1] == REG_MODULUS);
	assign cfg_write = psel && penable && pwrite && pready;
	assign pready    = 1'b1;
	assign prdata    = reg_hit ? DATA_W'(modulus_q) : '0;

	// hold the modulus; writes past the register list are dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			modulus_q <= MODULUS_RESET[MOD_BITS-1:0];
		end else if (cfg_write && reg_hit) begin
			modulus_q <= pwdata[MOD_BITS-1:0];
		end
	end

	// exponent scan and base reduction
	modexp_seq #(
		.EXP_BITS(EXP_BITS),
		.MOD_BITS(MOD_BITS)
	) u_seq (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (start),
		.cmd      (cmd),
		.base     (base),
		.exponent (exponent),
		.m        (modulus_q),
		.busy     (busy),
		.done     (done),
		.result   (result),
		.mul_start(mul_start),
		.mul_a    (mul_a),
		.mul_b    (mul_b),
		.mul_done (mul_done),
		.mul_prod (mul_prod)
	);

	// shared bit-serial modular multiplier
	modexp_mulser #(
		.MOD_BITS(MOD_BITS)
	) u_mulser (
		.clk   (clk),
		.arst_n(arst_n),
		.start (mul_start),
		.a     (mul_a),
		.b     (mul_b),
		.m     (modulus_q),
		.done  (mul_done),
		.prod  (mul_prod)
	);

endmodule

// ===== hdl/modexp_mulser.sv =====
// Bit-serial modular multiplier: prod = a * b mod m, one bit of b per cycle.
// Depends on nothing; instantiated by the top level.
`timescale 1ns / 1ps

module modexp_mulser #(
	parameter int MOD_BITS = 30
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	input  logic [MOD_BITS-1:0] a,
	input  logic [MOD_BITS-1:0] b,
	input  logic [MOD_BITS-1:0] m,
	output logic                done,
	output logic [MOD_BITS-1:0] prod
);

	localparam int CNT_W = $clog2(MOD_BITS);

	logic                run_q;
	logic                done_q;
	logic [CNT_W-1:0]    cnt_q;
	logic [MOD_BITS-1:0] a_q;
	logic [MOD_BITS-1:0] b_q;
	logic [MOD_BITS-1:0] r_q;

	logic [MOD_BITS:0]   dbl;
	logic [MOD_BITS:0]   dbl_red;
	logic [MOD_BITS:0]   sum;
	logic [MOD_BITS:0]   sum_red;
	logic [MOD_BITS-1:0] r_next;

	// r = 2r mod m, then add a mod m when the current bit of b is set
	always_comb begin
		dbl     = {r_q, 1'b0};
		dbl_red = (dbl >= {1'b0, m}) ? (dbl - {1'b0, m}) : dbl;
		sum     = dbl_red + {1'b0, a_q};
		sum_red = (sum >= {1'b0, m}) ? (sum - {1'b0, m}) : sum;
		r_next  = b_q[MOD_BITS-1] ? sum_red[MOD_BITS-1:0] : dbl_red[MOD_BITS-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
			a_q    <= '0;
			b_q    <= '0;
			r_q    <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				run_q <= 1'b1;
				cnt_q <= CNT_W'(MOD_BITS - 1);
				a_q   <= a;
				b_q   <= b;
				r_q   <= '0;
			end else if (run_q) begin
				r_q <= r_next;
				b_q <= {b_q[MOD_BITS-2:0], 1'b0};
				cnt_q <= cnt_q - CNT_W'(1);
				if (cnt_q == '0) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	assign done = done_q;
	assign prod = r_q;

endmodule

// ===== hdl/modexp_seq.sv =====
// Sequencer: base reduction, then square-and-multiply over the exponent bits.
// Depends on modexp_pkg; drives one modexp_mulser.
`timescale 1ns / 1ps

module modexp_seq #(
	parameter int EXP_BITS = 32,
	parameter int MOD_BITS = 30
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	input  logic                cmd,
	input  logic [MOD_BITS-1:0] base,
	input  logic [EXP_BITS-1:0] exponent,
	input  logic [MOD_BITS-1:0] m,
	output logic                busy,
	output logic                done,
	output logic [MOD_BITS-1:0] result,
	output logic                mul_start,
	output logic [MOD_BITS-1:0] mul_a,
	output logic [MOD_BITS-1:0] mul_b,
	input  logic                mul_done,
	input  logic [MOD_BITS-1:0] mul_prod
);

	import modexp_pkg::*;

	localparam int BIT_W  = $clog2(EXP_BITS);
	localparam int WIDE_W = (EXP_BITS > MOD_BITS) ? EXP_BITS : MOD_BITS;

	typedef enum logic [1:0] {
		IDLE,
		REDUCE,
		SQUARE,
		MULT
	} state_t;

	state_t              state_q;
	logic                done_q;
	logic                start_q;
	logic [MOD_BITS-1:0] result_q;
	logic [MOD_BITS-1:0] a_q;
	logic [MOD_BITS-1:0] b_q;
	logic [MOD_BITS-1:0] base_q;
	logic [EXP_BITS-1:0] exp_q;
	logic [BIT_W-1:0]    bit_q;

	logic                accept;
	logic                mod_small;
	logic [MOD_BITS-1:0] m_minus2;
	logic [WIDE_W-1:0]   inv_wide;
	logic [EXP_BITS-1:0] exp_sel;
	logic                last_bit;

	always_comb begin
		accept    = start && (state_q == IDLE);
		mod_small = ~|m[MOD_BITS-1:1];
		m_minus2  = m - MOD_BITS'(2);
		inv_wide  = WIDE_W'(m_minus2);
		exp_sel   = (cmd == CMD_POWER) ? exponent : inv_wide[EXP_BITS-1:0];
		last_bit  = (bit_q == '0);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= IDLE;
			done_q   <= 1'b0;
			start_q  <= 1'b0;
			result_q <= '0;
			a_q      <= '0;
			b_q      <= '0;
			base_q   <= '0;
			exp_q    <= '0;
			bit_q    <= '0;
		end else begin
			done_q  <= 1'b0;
			start_q <= 1'b0;
			case (state_q)
				IDLE: begin
					if (accept) begin
						if (mod_small) begin
							result_q <= '0;
							done_q   <= 1'b1;
						end else begin
							// reduce the base as 1 * base mod m
							exp_q   <= exp_sel;
							bit_q   <= BIT_W'(EXP_BITS - 1);
							a_q     <= MOD_BITS'(1);
							b_q     <= base;
							start_q <= 1'b1;
							state_q <= REDUCE;
						end
					end
				end
				REDUCE: begin
					if (mul_done) begin
						base_q  <= mul_prod;
						a_q     <= MOD_BITS'(1);
						b_q     <= MOD_BITS'(1);
						start_q <= 1'b1;
						state_q <= SQUARE;
					end
				end
				SQUARE: begin
					if (mul_done) begin
						if (exp_q[EXP_BITS-1]) begin
							a_q     <= mul_prod;
							b_q     <= base_q;
							start_q <= 1'b1;
							state_q <= MULT;
						end else if (last_bit) begin
							result_q <= mul_prod;
							done_q   <= 1'b1;
							state_q  <= IDLE;
						end else begin
							exp_q   <= {exp_q[EXP_BITS-2:0], 1'b0};
							bit_q   <= bit_q - BIT_W'(1);
							a_q     <= mul_prod;
							b_q     <= mul_prod;
							start_q <= 1'b1;
						end
					end
				end
				MULT: begin
					if (mul_done) begin
						if (last_bit) begin
							result_q <= mul_prod;
							done_q   <= 1'b1;
							state_q  <= IDLE;
						end else begin
							exp_q   <= {exp_q[EXP_BITS-2:0], 1'b0};
							bit_q   <= bit_q - BIT_W'(1);
							a_q     <= mul_prod;
							b_q     <= mul_prod;
							start_q <= 1'b1;
							state_q <= SQUARE;
						end
					end
				end
				default: begin
					state_q <= IDLE;
				end
			endcase
		end
	end

	assign busy      = (state_q != IDLE);
	assign done      = done_q;
	assign result    = result_q;
	assign mul_start = start_q;
	assign mul_a     = a_q;
	assign mul_b     = b_q;

endmodule

// ===== hdl/modexp_check.sv =====
// Port-level checker for the modular exponentiation unit, bound to the top level.
// Depends on modular_exponentiation_unit_assert.svh.
`timescale 1ns / 1ps
`include "modular_exponentiation_unit_assert.svh"

module modexp_check (
	input logic clk,
	input logic arst_n,
	input logic start,
	input logic busy,
	input logic done
);

	// a result word shows only with the block idle
	`MEU_ASSERT_SAME(a_done_idle, clk, arst_n, done, !busy, "result shown while busy")
	// busy rises only after an accepted command
	`MEU_ASSERT_SAME(a_busy_cause, clk, arst_n, $rose(busy), $past(start), "busy without command")
	// once busy, stay busy until a result word appears
	`MEU_ASSERT_NEXT(a_busy_hold, clk, arst_n, busy, busy || done, "busy dropped without result")
	// a result word follows work in progress or a command taken
	`MEU_ASSERT_SAME(a_done_cause, clk, arst_n, done, $past(busy) || $past(start),
		"result without command")

endmodule

bind modular_exponentiation_unit modexp_check u_modexp_check (
	.clk   (clk),
	.arst_n(arst_n),
	.start (start),
	.busy  (busy),
	.done  (done)
);

// ===== test/tb_modular_exponentiation_unit.sv =====
// Self-checking testbench of the modular exponentiation unit: directed table, then random words.
// Depends on modexp_pkg and modular_exponentiation_unit, and so on the files that the unit depends on.
`timescale 1ns / 1ps

module tb_modular_exponentiation_unit;
	import modexp_pkg::*;

	localparam int MOD_W  = 30;
	localparam int EXP_W  = 32;
	localparam int DATA_W = 32;
	localparam int ADDR_W = 3;

	// byte address of the modulus register
	localparam logic [ADDR_W-1:0] MODULUS_ADDR = ADDR_W'(REG_MODULUS * 4);
	localparam logic [63:0] BASE_MAX = (64'd1 << MOD_W) - 1;
	// longest command: one reduction, one square per bit, one multiply per bit
	localparam int WORST_LATENCY = (MOD_W + 2) * (1 + 2 * EXP_W) + 1;
	localparam int RANDOM_PHASES = 12;
	localparam int WORDS_PER_PHASE = 108;

	// one row of the directed table; value counts only where known is set
	typedef struct packed {
		logic [DATA_W-1:0] modulus_word;
		logic              op;
		logic [MOD_W-1:0]  base;
		logic [EXP_W-1:0]  exponent;
		logic              known;
		logic [MOD_W-1:0]  value;
	} stim_row_t;

	typedef struct {
		int               tag;
		logic [MOD_W-1:0] value;
	} expected_power_t;

	logic              clk     = 1'b0;
	logic              arst_n  = 1'b0;
	logic              psel    = 1'b0;
	logic              penable = 1'b0;
	logic              pwrite  = 1'b0;
	logic [ADDR_W-1:0] paddr   = '0;
	logic [DATA_W-1:0] pwdata  = '0;
	logic [DATA_W-1:0] prdata;
	logic              pready;
	logic              start    = 1'b0;
	logic              busy;
	logic              cmd      = CMD_POWER;
	logic [MOD_W-1:0]  base     = '0;
	logic [EXP_W-1:0]  exponent = '0;
	logic              done;
	logic [MOD_W-1:0]  result;

	// modulus as the block holds it, tracked by every register write
	logic [MOD_W-1:0] modulus_now = MODULUS_RESET[MOD_W-1:0];
	expected_power_t  pending_powers[$];
	int               mismatch_count = 0;
	int               words_issued   = 0;
	int               idle_free_left = 0;

	// Directed table: reset modulus first, then the small and odd moduli.
	stim_row_t directed_rows [0:26] = '{
		// exponent zero, zero base, base a multiple of the modulus, 2^10 and (m-1)^2
		'{32'd1000000007, CMD_POWER,   30'd0,          32'd0,          1'b1, 30'd1},
		'{32'd1000000007, CMD_POWER,   30'd5,          32'd0,          1'b1, 30'd1},
		'{32'd1000000007, CMD_POWER,   30'd0,          32'd5,          1'b1, 30'd0},
		'{32'd1000000007, CMD_POWER,   30'd1000000007, 32'd3,          1'b1, 30'd0},
		'{32'd1000000007, CMD_POWER,   30'd2,          32'd10,         1'b1, 30'd1024},
		'{32'd1000000007, CMD_POWER,   30'd1000000006, 32'd2,          1'b1, 30'd1},
		// oversized base and full exponent
		'{32'd1000000007, CMD_POWER,   30'h3FFFFFFF,   32'hFFFFFFFF,   1'b0, 30'd0},
		'{32'd1000000007, CMD_POWER,   30'h3FFFFFFF,   32'd1,          1'b1, 30'd73741816},
		'{32'd1000000007, CMD_POWER,   30'd3,          32'hFFFFFFFF,   1'b0, 30'd0},
		// inverse ignores the exponent field
		'{32'd1000000007, CMD_INVERSE, 30'd1,          32'd0,          1'b1, 30'd1},
		'{32'd1000000007, CMD_INVERSE, 30'd2,          32'hFFFFFFFF,   1'b1, 30'd500000004},
		'{32'd1000000007, CMD_INVERSE, 30'd0,          32'd0,          1'b1, 30'd0},
		'{32'd1000000007, CMD_INVERSE, 30'd1000000007, 32'h5A5A5A5A,   1'b1, 30'd0},
		'{32'd1000000007, CMD_INVERSE, 30'h3FFFFFFF,   32'd0,          1'b0, 30'd0},
		// smallest legal modulus; inverse then uses exponent zero
		'{32'd2,          CMD_POWER,   30'd3,          32'd0,          1'b1, 30'd1},
		'{32'd2,          CMD_POWER,   30'd3,          32'd7,          1'b1, 30'd1},
		'{32'd2,          CMD_POWER,   30'd2,          32'd5,          1'b1, 30'd0},
		'{32'd2,          CMD_INVERSE, 30'd4,          32'd0,          1'b1, 30'd1},
		// modulus below two gives zero for everything
		'{32'd0,          CMD_POWER,   30'd5,          32'd0,          1'b1, 30'd0},
		'{32'd0,          CMD_INVERSE, 30'd7,          32'd3,          1'b1, 30'd0},
		'{32'd1,          CMD_POWER,   30'd9,          32'd0,          1'b1, 30'd0},
		'{32'd1,          CMD_INVERSE, 30'h3FFFFFFF,   32'hFFFFFFFF,   1'b1, 30'd0},
		// largest modulus, composite; then modulus 3
		'{32'd1073741823, CMD_POWER,   30'h3FFFFFFE,   32'hFFFFFFFF,   1'b0, 30'd0},
		'{32'd1073741823, CMD_INVERSE, 30'd2,          32'd0,          1'b0, 30'd0},
		'{32'd1073741823, CMD_POWER,   30'h3FFFFFFF,   32'd2,          1'b1, 30'd0},
		'{32'd3,          CMD_INVERSE, 30'd2,          32'd0,          1'b1, 30'd2},
		// upper write bits drop: modulus becomes 7, 3^5 mod 7
		'{32'hC0000007,   CMD_INVERSE, 30'd3,          32'd0,          1'b1, 30'd5}
	};

	modular_exponentiation_unit #(
		.EXP_BITS(EXP_W),
		.MOD_BITS(MOD_W)
	) dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.start   (start),
		.busy    (busy),
		.cmd     (cmd),
		.base    (base),
		.exponent(exponent),
		.done    (done),
		.result  (result)
	);

	always #2 clk = ~clk;

	// Left-to-right square and multiply on native products; operands stay below
	// 2^30, so every product fits in 64 bits.
	function automatic logic [MOD_W-1:0] power_mod_predict(input logic op,
			input logic [MOD_W-1:0] b, input logic [EXP_W-1:0] e,
			input logic [MOD_W-1:0] m);
		logic [63:0]      acc;
		logic [63:0]      bb;
		logic [63:0]      mm;
		logic [EXP_W-1:0] ee;
		if (m < 2)
			return '0;
		mm  = 64'(m);
		bb  = 64'(b) % mm;
		ee  = (op == CMD_INVERSE) ? EXP_W'(m - 2) : e;
		acc = 64'd1;
		for (int i = EXP_W - 1; i >= 0; i--) begin
			acc = (acc * acc) % mm;
			if (ee[i])
				acc = (acc * bb) % mm;
		end
		return acc[MOD_W-1:0];
	endfunction

	// Mostly short gaps, a few long ones, and now and then a run with none.
	function automatic int pick_gap();
		int r;
		if (idle_free_left > 0) begin
			idle_free_left--;
			return 0;
		end
		if ($urandom_range(0, 49) == 0) begin
			idle_free_left = $urandom_range(10, 40);
			return 0;
		end
		r = $urandom_range(0, 99);
		if (r < 50)
			return 0;
		else if (r < 85)
			return $urandom_range(1, 3);
		else if (r < 97)
			return $urandom_range(4, 15);
		else
			return $urandom_range(30, 120);
	endfunction

	function automatic logic [DATA_W-1:0] phase_modulus(input int phase);
		case (phase)
			0: return 32'd1000000007;
			1: return 32'd2;
			2: return 32'd3;
			3: return 32'd1073741823;
			4: return 32'd0;
			5: return 32'd1;
			6: return 32'd998244353;
			7: return 32'd1073741789;
			8: return 32'($urandom_range(2, 300));
			default: return $urandom();
		endcase
	endfunction

	task automatic note_failure(input string msg);
		mismatch_count++;
		if (mismatch_count <= 10)
			$display("%s", msg);
	endtask

	// Drop start and hold until the block is idle and every result is in.
	task automatic settle_idle();
		start <= 1'b0;
		do
			@(posedge clk);
		while (busy || pending_powers.size() != 0);
	endtask

	// Setup cycle, then access cycle; the register lands at the edge with pready high.
	task automatic write_modulus(input logic [DATA_W-1:0] word);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= MODULUS_ADDR;
		pwdata  <= word;
		@(posedge clk);
		penable <= 1'b1;
		do
			@(posedge clk);
		while (!pready);
		psel        <= 1'b0;
		penable     <= 1'b0;
		pwrite      <= 1'b0;
		modulus_now = word[MOD_W-1:0];
	endtask

	// Idle for a random gap with junk on the fields, then present the word and
	// hold it until the edge that takes it; queue its expected result there.
	task automatic issue_word(input logic op, input logic [MOD_W-1:0] b,
			input logic [EXP_W-1:0] e, input logic known, input logic [MOD_W-1:0] value);
		int              gap;
		expected_power_t entry;
		gap = pick_gap();
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) begin
				cmd      <= 1'($urandom());
				base     <= MOD_W'($urandom());
				exponent <= $urandom();
				@(posedge clk);
			end
		end
		start    <= 1'b1;
		cmd      <= op;
		base     <= b;
		exponent <= e;
		do
			@(posedge clk);
		while (!(start && !busy));
		entry.tag   = words_issued;
		entry.value = known ? value : power_mod_predict(op, b, e, modulus_now);
		pending_powers.push_back(entry);
		words_issued++;
	endtask

	// Random word shaped around the current modulus: zero, multiples, m-1,
	// tiny and full-width bases; zero, one, all-ones and small exponents.
	task automatic issue_random_word();
		logic             op;
		logic [MOD_W-1:0] b;
		logic [EXP_W-1:0] e;
		logic [63:0]      k_max;
		op = 1'($urandom());
		case ($urandom_range(0, 9))
			0: b = '0;
			1: begin
				if (modulus_now >= 2) begin
					k_max = BASE_MAX / 64'(modulus_now);
					b = MOD_W'(64'(modulus_now) * $urandom_range(1, 32'(k_max)));
				end else begin
					b = modulus_now;
				end
			end
			2: b = modulus_now - 1'b1;
			3: b = MOD_W'($urandom_range(0, 15));
			4: b = '1;
			default: b = MOD_W'($urandom());
		endcase
		case ($urandom_range(0, 9))
			0: e = '0;
			1: e = 32'd1;
			2: e = '1;
			3: e = 32'($urandom_range(2, 64));
			default: e = $urandom();
		endcase
		issue_word(op, b, e, 1'b0, '0);
	endtask

	// Check every strobed result against the oldest expectation.
	always @(posedge clk) begin
		expected_power_t head;
		if (arst_n && done) begin
			if (pending_powers.size() == 0) begin
				note_failure($sformatf("unexpected result %0d with nothing pending", result));
			end else begin
				head = pending_powers.pop_front();
				if (result !== head.value)
					note_failure($sformatf("word %0d: result expected %0d, got %0d",
						head.tag, head.value, result));
			end
		end
	end

	initial begin
		stim_row_t         row;
		logic [DATA_W-1:0] last_word;
		last_word = 32'd1000000007;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed table; rewrite the modulus only between groups, with the block idle.
		for (int i = 0; i < $size(directed_rows); i++) begin
			row = directed_rows[i];
			if (row.modulus_word !== last_word) begin
				settle_idle();
				write_modulus(row.modulus_word);
				last_word = row.modulus_word;
			end
			issue_word(row.op, row.base, row.exponent, row.known, row.value);
		end

		// Random phases, each under its own modulus.
		for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
			settle_idle();
			write_modulus(phase_modulus(phase));
			repeat (WORDS_PER_PHASE) issue_random_word();
		end

		// Drain, then watch a full command time for stray strobes.
		settle_idle();
		repeat (WORST_LATENCY + 100) @(posedge clk);
		if (mismatch_count == 0 && pending_powers.size() == 0)
			$display("modular_exponentiation_unit regression: pass");
		else
			$display("modular_exponentiation_unit regression: fail");
		$finish;
	end

	// Hard stop well past the slowest correct run.
	initial begin
		#60_000_000;
		$display("modular_exponentiation_unit regression: fail");
		$finish;
	end

endmodule

// ===== modular_exponentiation_unit.f =====
+incdir+hdl
hdl/modexp_pkg.sv
hdl/modexp_mulser.sv
hdl/modexp_seq.sv
hdl/modular_exponentiation_unit.sv
hdl/modexp_check.sv
test/tb_modular_exponentiation_unit.sv
